[rtl/core/periodic_task_edf_rms_scheduler_top_macros.svh]
// assertion helpers shared by the scheduler rtl
`ifndef PERIODIC_TASK_EDF_RMS_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_TASK_EDF_RMS_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define PTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ptsched_pkg.sv]
package ptsched_pkg;

   localparam int MODE_BITS      = 1;
   localparam int INDEX_BITS     = 3;
   localparam int FIELD_BITS     = 12;
   localparam int JOB_BITS       = 16;
   localparam int COUNT_BITS     = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;

   typedef logic [MODE_BITS-1:0]      mode_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam mode_type MODE_TICK = 1'b0;
   localparam mode_type MODE_LOAD = 1'b1;

   localparam logic POLICY_EDF = 1'b0;
   localparam logic POLICY_RMS = 1'b1;

   localparam csr_index_type REG_POLICY     = 2'd0;
   localparam csr_index_type REG_TASK_COUNT = 2'd1;

   localparam logic [COUNT_BITS-1:0] TASK_COUNT_RESET = 4'd1;

endpackage

[rtl/core/ptsched_req_if.sv]
interface ptsched_req_if
   import ptsched_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [MODE_BITS-1:0]  mode;
   logic [INDEX_BITS-1:0] task_index;
   logic [FIELD_BITS-1:0] compute_time;
   logic [FIELD_BITS-1:0] period;

   modport source (output valid, mode, task_index, compute_time, period, input ready);
   modport sink   (input valid, mode, task_index, compute_time, period, output ready);
endinterface

[rtl/core/ptsched_rsp_if.sv]
interface ptsched_rsp_if
   import ptsched_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  idle;
   logic [INDEX_BITS-1:0] running_task;
   logic [JOB_BITS-1:0]   job_number;
   logic                  job_done;

   modport source (output valid, idle, running_task, job_number, job_done, input ready);
   modport sink   (input valid, idle, running_task, job_number, job_done, output ready);
endinterface

[rtl/core/ptsched_csr_if.sv]
interface ptsched_csr_if
   import ptsched_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ptsched_ram.sv]
module ptsched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/core/periodic_task_edf_rms_scheduler_top.sv]
// Periodic task scheduler, EDF or non-preemptive RMS. A load word writes one task entry
// and gives no response. A tick word passes over the task memory once or twice, one
// entry per cycle through its single read port: a scan over the n entries in use picks
// the task (skipped under RMS while the last task still runs), then an update pass
// counts down deadlines and retires the running job. The response sits in an output
// register, so the next word is taken while a response waits.
`include "periodic_task_edf_rms_scheduler_top_macros.svh"

module periodic_task_edf_rms_scheduler_top
   import ptsched_pkg::*;
#(
   parameter int MAX_TASKS = 8,
   parameter int TIME_BITS = 12
) (
   input logic         clock,
   input logic         reset,
   ptsched_req_if.sink req_ch,
   ptsched_rsp_if.source rsp_ch,
   ptsched_csr_if.sink csr_ch
);
   localparam int IDX_BITS  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
   localparam int WORD_BITS = 4 * TIME_BITS + JOB_BITS;
   localparam int DL_LO     = JOB_BITS;
   localparam int CL_LO     = DL_LO + TIME_BITS;
   localparam int PER_LO    = CL_LO + TIME_BITS;
   localparam int CMP_LO    = PER_LO + TIME_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  policy_ff, policy_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [MAX_TASKS-1:0]  active_ff, active_in;
   logic                  choice_valid_ff, choice_valid_in;
   logic [IDX_BITS-1:0]   last_choice_ff, last_choice_in;
   logic                  pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]   pidx_ff, pidx_in;
   logic                  ran_ff, ran_in;
   logic [IDX_BITS-1:0]   pick_ff, pick_in;
   logic [TIME_BITS-1:0]  key_ff, key_in;
   logic [JOB_BITS-1:0]   res_job_ff, res_job_in;
   logic                  res_done_ff, res_done_in;
   logic                  rsp_idle_ff, rsp_idle_in;
   logic [INDEX_BITS-1:0] rsp_task_ff, rsp_task_in;
   logic [JOB_BITS-1:0]   rsp_job_ff, rsp_job_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic                  ram_we;
   logic [IDX_BITS-1:0]   ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic [IDX_BITS-1:0]   ram_raddr;
   logic [WORD_BITS-1:0]  ram_rdata;

   logic [CNT_BITS-1:0]   n_use;
   logic [CNT_BITS-1:0]   upd_lim;
   logic                  issue;
   logic                  held;

   ptsched_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_TASKS)
   ) u_task_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (int'(count_ff) > MAX_TASKS) begin
         n_use = CNT_BITS'(MAX_TASKS);
      end else begin
         n_use = CNT_BITS'(count_ff);
      end
      // a held rms choice beyond the count still needs its own update
      if (ran_ff && (CNT_BITS'(pick_ff) >= n_use)) begin
         upd_lim = CNT_BITS'(pick_ff) + 1'b1;
      end else begin
         upd_lim = n_use;
      end
      if (state_ff == S_SCAN) begin
         issue = cnt_ff < n_use;
      end else begin
         issue = (state_ff == S_UPD) && (cnt_ff < upd_lim);
      end
      held = (policy_ff == POLICY_RMS) && choice_valid_ff && active_ff[last_choice_ff];
   end

   assign ram_raddr    = cnt_ff[IDX_BITS-1:0];
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.idle         = rsp_idle_ff;
   assign rsp_ch.running_task = rsp_task_ff;
   assign rsp_ch.job_number   = rsp_job_ff;
   assign rsp_ch.job_done     = rsp_done_ff;

   always_comb begin
      logic [TIME_BITS-1:0] key;
      logic [TIME_BITS-1:0] e_cmp;
      logic [TIME_BITS-1:0] e_per;
      logic [TIME_BITS-1:0] e_cl;
      logic [TIME_BITS-1:0] e_dl;
      logic [JOB_BITS-1:0]  e_job;
      logic                 e_act;

      state_in        = state_ff;
      policy_in       = policy_ff;
      count_in        = count_ff;
      active_in       = active_ff;
      choice_valid_in = choice_valid_ff;
      last_choice_in  = last_choice_ff;
      pend_in         = pend_ff;
      cnt_in          = cnt_ff;
      pidx_in         = pidx_ff;
      ran_in          = ran_ff;
      pick_in         = pick_ff;
      key_in          = key_ff;
      res_job_in      = res_job_ff;
      res_done_in     = res_done_ff;
      rsp_idle_in     = rsp_idle_ff;
      rsp_task_in     = rsp_task_ff;
      rsp_job_in      = rsp_job_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      ram_we          = 1'b0;
      ram_waddr       = pidx_ff;
      ram_wdata       = ram_rdata;

      e_cmp = ram_rdata[CMP_LO +: TIME_BITS];
      e_per = ram_rdata[PER_LO +: TIME_BITS];
      e_cl  = ram_rdata[CL_LO +: TIME_BITS];
      e_dl  = ram_rdata[DL_LO +: TIME_BITS];
      e_job = ram_rdata[JOB_BITS-1:0];
      e_act = active_ff[pidx_ff];
      key   = (policy_ff == POLICY_RMS) ? e_per : e_dl;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_POLICY:     policy_in = csr_ch.data[0];
            REG_TASK_COUNT: count_in  = csr_ch.data[COUNT_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.mode == MODE_LOAD) begin
                  if (int'(req_ch.task_index) < MAX_TASKS) begin
                     ram_we    = 1'b1;
                     ram_waddr = IDX_BITS'(req_ch.task_index);
                     ram_wdata = {TIME_BITS'(req_ch.compute_time),
                                  TIME_BITS'(req_ch.period),
                                  TIME_BITS'(req_ch.compute_time),
                                  TIME_BITS'(req_ch.period),
                                  JOB_BITS'(1)};
                     active_in[IDX_BITS'(req_ch.task_index)] = 1'b1;
                  end
               end else begin
                  cnt_in  = '0;
                  pend_in = 1'b0;
                  if (held) begin
                     ran_in   = 1'b1;
                     pick_in  = last_choice_ff;
                     state_in = S_UPD;
                  end else begin
                     ran_in   = 1'b0;
                     pick_in  = '0;
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            pend_in = issue;
            pidx_in = cnt_ff[IDX_BITS-1:0];
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (pend_ff && active_ff[pidx_ff]) begin
               if (!ran_ff || (key < key_ff)) begin
                  ran_in  = 1'b1;
                  key_in  = key;
                  pick_in = pidx_ff;
               end
            end
            if (!issue && !pend_ff) begin
               cnt_in   = '0;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            pend_in = issue;
            pidx_in = cnt_ff[IDX_BITS-1:0];
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               if (ran_ff && (pidx_ff == pick_ff)) begin
                  res_job_in = e_job;
                  if (e_cl != '0) begin
                     e_cl = e_cl - 1'b1;
                  end
                  res_done_in = (e_cl == '0);
                  if (e_cl == '0) begin
                     e_act = 1'b0;
                     e_job = e_job + 1'b1;
                  end
               end
               if (CNT_BITS'(pidx_ff) < n_use) begin
                  e_dl = e_dl - 1'b1;
                  if (e_dl == '0) begin
                     e_dl  = e_per;
                     e_cl  = e_cmp;
                     e_act = 1'b1;
                  end
               end
               ram_we             = 1'b1;
               ram_waddr          = pidx_ff;
               ram_wdata          = {e_cmp, e_per, e_cl, e_dl, e_job};
               active_in[pidx_ff] = e_act;
            end
            if (!issue && !pend_ff) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_idle_in     = !ran_ff;
               rsp_task_in     = ran_ff ? INDEX_BITS'(pick_ff) : '0;
               rsp_job_in      = ran_ff ? res_job_ff : '0;
               rsp_done_in     = ran_ff && res_done_ff;
               choice_valid_in = ran_ff;
               last_choice_in  = ran_ff ? pick_ff : '0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         policy_ff       <= POLICY_EDF;
         count_ff        <= TASK_COUNT_RESET;
         active_ff       <= '0;
         choice_valid_ff <= 1'b0;
         last_choice_ff  <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         policy_ff       <= policy_in;
         count_ff        <= count_in;
         active_ff       <= active_in;
         choice_valid_ff <= choice_valid_in;
         last_choice_ff  <= last_choice_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pidx_ff     <= pidx_in;
      ran_ff      <= ran_in;
      pick_ff     <= pick_in;
      key_ff      <= key_in;
      res_job_ff  <= res_job_in;
      res_done_ff <= res_done_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_task_ff <= rsp_task_in;
      rsp_job_ff  <= rsp_job_in;
      rsp_done_ff <= rsp_done_in;
   end

   `PTS_ASSERT_NOW(a_no_write_in_scan, clock, reset, state_ff == S_SCAN, !ram_we, "task memory written during scan")
   `PTS_ASSERT_NOW(a_idle_word_clean, clock, reset, rsp_valid_ff && rsp_idle_ff, rsp_task_ff == '0 && rsp_job_ff == '0 && !rsp_done_ff, "idle response carries task data")
   `PTS_ASSERT_NEXT(a_out_to_idle, clock, reset, state_ff == S_OUT && (!rsp_valid_ff || rsp_ch.ready), state_ff == S_IDLE && rsp_valid_ff, "response not loaded on exit")
   `PTS_ASSERT_NOW(a_no_read_pending, clock, reset, state_ff == S_IDLE || state_ff == S_OUT, !pend_ff, "memory read pending outside a pass")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import ptsched_pkg::*;

   localparam int TABLE_SIZE    = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASES        = 12;
   localparam int PHASE_WORDS   = 165;

   localparam csr_index_type REG_SPARE_LO = 2'd2;
   localparam csr_index_type REG_SPARE_HI = 2'd3;

   typedef struct packed {
      logic                  idle;
      logic [INDEX_BITS-1:0] task_id;
      logic [JOB_BITS-1:0]   job;
      logic                  done;
   } run_report_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      mode_type                 mode;
      logic [INDEX_BITS-1:0]    slot;
      logic [FIELD_BITS-1:0]    work;
      logic [FIELD_BITS-1:0]    interval;
      csr_index_type            reg_index;
      logic [CSR_DATA_BITS-1:0] reg_data;
      bit                       typed;
      run_report_type           report;
   } script_row_type;

   logic clock;
   logic reset;

   ptsched_req_if req_ch ();
   ptsched_rsp_if rsp_ch ();
   ptsched_csr_if csr_ch ();

   periodic_task_edf_rms_scheduler_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // scheduler state as seen by the checker
   logic                  sched_policy;
   logic [COUNT_BITS-1:0] sched_count;
   logic [FIELD_BITS-1:0] task_work [TABLE_SIZE];
   logic [FIELD_BITS-1:0] task_interval [TABLE_SIZE];
   logic [FIELD_BITS-1:0] work_left [TABLE_SIZE];
   logic [FIELD_BITS-1:0] time_left [TABLE_SIZE];
   logic [JOB_BITS-1:0]   job_seq [TABLE_SIZE];
   bit                    task_ready [TABLE_SIZE];
   bit                    held_valid;
   logic [INDEX_BITS-1:0] held_task;

   run_report_type expected_runs [$];
   script_row_type stimulus_script [$];

   int fail_count;
   int quiet_cycles;
   bit gaps_on;
   bit stalls_on;
   bit hold_request;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int slots_in_use();
      return (int'(sched_count) > TABLE_SIZE) ? TABLE_SIZE : int'(sched_count);
   endfunction

   function automatic bit schedule_word(input mode_type mode,
                                        input logic [INDEX_BITS-1:0] slot,
                                        input logic [FIELD_BITS-1:0] work,
                                        input logic [FIELD_BITS-1:0] interval,
                                        output run_report_type rep);
      int n;
      int pick;
      int j;
      bit found;
      logic [FIELD_BITS-1:0] key;
      logic [FIELD_BITS-1:0] best_key;
      rep = '0;
      if (mode == MODE_LOAD) begin
         task_work[slot] = work;
         task_interval[slot] = interval;
         work_left[slot] = work;
         time_left[slot] = interval;
         task_ready[slot] = 1'b1;
         job_seq[slot] = 16'd1;
         return 1'b0;
      end
      n = slots_in_use();
      found = 1'b0;
      pick = 0;
      best_key = '0;
      // rms keeps a running task even past the count
      if (sched_policy == POLICY_RMS && held_valid && task_ready[held_task]) begin
         found = 1'b1;
         pick = int'(held_task);
      end else begin
         for (j = 0; j < n; j++) begin
            if (task_ready[j]) begin
               key = (sched_policy == POLICY_RMS) ? task_interval[j] : time_left[j];
               if (!found || key < best_key) begin
                  found = 1'b1;
                  best_key = key;
                  pick = j;
               end
            end
         end
      end
      if (found) begin
         rep.idle = 1'b0;
         rep.task_id = pick[INDEX_BITS-1:0];
         rep.job = job_seq[pick];
         if (work_left[pick] != 0)
            work_left[pick] = work_left[pick] - 1'b1;
         rep.done = (work_left[pick] == 0);
         if (rep.done) begin
            task_ready[pick] = 1'b0;
            job_seq[pick] = job_seq[pick] + 1'b1;
         end
         held_valid = 1'b1;
         held_task = pick[INDEX_BITS-1:0];
      end else begin
         rep.idle = 1'b1;
         held_valid = 1'b0;
         held_task = '0;
      end
      for (j = 0; j < n; j++) begin
         time_left[j] = time_left[j] - 1'b1;
         if (time_left[j] == 0) begin
            time_left[j] = task_interval[j];
            work_left[j] = task_work[j];
            task_ready[j] = 1'b1;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [FIELD_BITS-1:0] rand_work();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FIELD_BITS'($urandom());
         2: return '1;
         default: return FIELD_BITS'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [FIELD_BITS-1:0] rand_interval();
      case ($urandom_range(0, 19))
         0: return '0;
         1, 2: return FIELD_BITS'($urandom());
         3: return '1;
         default: return FIELD_BITS'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic script_row_type load_row(input int slot, input int work, input int interval);
      script_row_type row;
      row = '{kind: ROW_WORD, default: '0};
      row.mode = MODE_LOAD;
      row.slot = INDEX_BITS'(slot);
      row.work = FIELD_BITS'(work);
      row.interval = FIELD_BITS'(interval);
      return row;
   endfunction

   function automatic script_row_type tick_row(input bit typed, input run_report_type rep);
      script_row_type row;
      row = '{kind: ROW_WORD, default: '0};
      row.mode = MODE_TICK;
      row.slot = INDEX_BITS'($urandom());
      row.work = FIELD_BITS'($urandom());
      row.interval = FIELD_BITS'($urandom());
      row.typed = typed;
      row.report = rep;
      return row;
   endfunction

   function automatic script_row_type csr_row(input csr_index_type idx,
                                              input logic [CSR_DATA_BITS-1:0] data);
      script_row_type row;
      row = '{kind: ROW_CSR, default: '0};
      row.reg_index = idx;
      row.reg_data = data;
      return row;
   endfunction

   task automatic send_word(input mode_type mode, input logic [INDEX_BITS-1:0] slot,
                            input logic [FIELD_BITS-1:0] work,
                            input logic [FIELD_BITS-1:0] interval,
                            input bit typed, input run_report_type typed_rep);
      run_report_type rep;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.task_index <= slot;
      req_ch.compute_time <= work;
      req_ch.period <= interval;
      do @(posedge clock); while (!req_ch.ready);
      if (schedule_word(mode, slot, work, interval, rep))
         expected_runs.push_back(typed ? typed_rep : rep);
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      settle_block();
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == REG_POLICY)
         sched_policy = data[0];
      else if (idx == REG_TASK_COUNT)
         sched_count = data;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic flag_field(input string what, input logic [JOB_BITS-1:0] want,
                             input logic [JOB_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // result side: random stalls plus one long hold
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      run_report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_runs.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual idle %0d task %0d job %0d done %0d",
                     $time, rsp_ch.idle, rsp_ch.running_task, rsp_ch.job_number,
                     rsp_ch.job_done);
            fail_count++;
         end else begin
            want = expected_runs.pop_front();
            flag_field("idle", JOB_BITS'(want.idle), JOB_BITS'(rsp_ch.idle));
            flag_field("running_task", JOB_BITS'(want.task_id),
                       JOB_BITS'(rsp_ch.running_task));
            flag_field("job_number", want.job, rsp_ch.job_number);
            flag_field("job_done", JOB_BITS'(want.done), JOB_BITS'(rsp_ch.job_done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      script_row_type row;
      int phase;
      int j;
      int k;
      int lanes;
      int in_use;
      bit last_phase;
      logic [CSR_DATA_BITS-1:0] pol_data;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_TICK;
      req_ch.task_index = '0;
      req_ch.compute_time = '0;
      req_ch.period = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_POLICY;
      csr_ch.data = '0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      hold_request = 1'b0;

      sched_policy = POLICY_EDF;
      sched_count = TASK_COUNT_RESET;
      held_valid = 1'b0;
      held_task = '0;
      for (j = 0; j < TABLE_SIZE; j++) begin
         task_work[j] = '0;
         task_interval[j] = '0;
         work_left[j] = '0;
         time_left[j] = '0;
         job_seq[j] = '0;
         task_ready[j] = 1'b0;
      end

      // no entries scanned, then an entry loaded past the count
      stimulus_script.push_back(csr_row(REG_TASK_COUNT, 4'd0));
      stimulus_script.push_back(tick_row(1'b1, '{1'b1, 3'd0, 16'd0, 1'b0}));
      stimulus_script.push_back(load_row(7, 4095, 4095));
      stimulus_script.push_back(tick_row(1'b1, '{1'b1, 3'd0, 16'd0, 1'b0}));
      // unit task, zero compute, zero period
      stimulus_script.push_back(load_row(0, 1, 1));
      stimulus_script.push_back(load_row(1, 0, 3));
      stimulus_script.push_back(load_row(2, 2, 0));
      stimulus_script.push_back(csr_row(REG_TASK_COUNT, 4'd1));
      stimulus_script.push_back(tick_row(1'b1, '{1'b0, 3'd0, 16'd1, 1'b1}));
      stimulus_script.push_back(tick_row(1'b1, '{1'b0, 3'd0, 16'd2, 1'b1}));
      stimulus_script.push_back(csr_row(REG_TASK_COUNT, 4'd3));
      for (j = 0; j < 5; j++)
         stimulus_script.push_back(tick_row(1'b0, '0));
      stimulus_script.push_back(csr_row(REG_POLICY, 4'd1));
      stimulus_script.push_back(load_row(3, 3, 4095));
      stimulus_script.push_back(load_row(4, 4095, 1));
      stimulus_script.push_back(load_row(5, 5, 7));
      stimulus_script.push_back(load_row(6, 1, 2));
      // count above the table size
      stimulus_script.push_back(csr_row(REG_TASK_COUNT, 4'd15));
      for (j = 0; j < 5; j++)
         stimulus_script.push_back(tick_row(1'b0, '0));
      // held rms choice beyond a shrunken count
      stimulus_script.push_back(csr_row(REG_TASK_COUNT, 4'd2));
      for (j = 0; j < 3; j++)
         stimulus_script.push_back(tick_row(1'b0, '0));
      stimulus_script.push_back(csr_row(REG_POLICY, 4'd0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stimulus_script[i]) begin
         row = stimulus_script[i];
         if (row.kind == ROW_CSR)
            write_reg(row.reg_index, row.reg_data);
         else
            send_word(row.mode, row.slot, row.work, row.interval, row.typed, row.report);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         last_phase = (phase >= PHASES - 2);
         gaps_on = !last_phase && ($urandom_range(0, 3) != 0);
         stalls_on = !last_phase && ($urandom_range(0, 3) != 0);
         case (phase)
            0, 1: lanes = 8;
            2: lanes = 1;
            3: lanes = 15;
            4: lanes = 0;
            default: lanes = $urandom_range(0, 15);
         endcase
         pol_data = CSR_DATA_BITS'($urandom_range(0, 15));
         if (phase < 4)
            pol_data[0] = phase[0];
         write_reg(REG_POLICY, pol_data);
         write_reg(REG_TASK_COUNT, CSR_DATA_BITS'(lanes));
         if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CSR_DATA_BITS'($urandom_range(0, 15)));
         if (phase == 1)
            hold_request = 1'b1;
         in_use = (lanes > TABLE_SIZE) ? TABLE_SIZE : lanes;
         for (j = 0; j < in_use; j++)
            if ($urandom_range(0, 1) == 1)
               send_word(MODE_LOAD, INDEX_BITS'(j), rand_work(), rand_interval(), 1'b0, '0);
         for (k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(0, 4) == 0)
               send_word(MODE_LOAD, INDEX_BITS'($urandom_range(0, 7)), rand_work(),
                         rand_interval(), 1'b0, '0);
            else
               send_word(MODE_TICK, INDEX_BITS'($urandom()), FIELD_BITS'($urandom()),
                         FIELD_BITS'($urandom()), 1'b0, '0);
         end
      end

      settle_block();
      if (fail_count == 0 && expected_runs.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
